// ===== sv/msc_pkg.sv =====
// Shared types and constants for the MultiSwap chain-and-decrypt core.
// Used by the key file, the multiplier and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

   localparam int unsigned KEY_W      = 32;
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned NUM_PAIRS  = 6;
   localparam int unsigned KIDX_W     = 4;
   localparam int unsigned CSR_ADDR_W = 3;

   typedef logic [KEY_W-1:0]      half_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [KIDX_W-1:0]     kidx_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

endpackage : msc_pkg

`default_nettype wire

// ===== sv/msc_mul.sv =====
// Shared 32 by 32 multiplier that keeps the low 32 bits of the product.
// Depends on msc_pkg for the operand type.
`timescale 1ns / 1ps
`default_nettype none

module msc_mul (
   input  wire msc_pkg::half_type op_a,
   input  wire msc_pkg::half_type op_b,
   output msc_pkg::half_type      product
);
   import msc_pkg::*;

   logic [2*KEY_W-1:0] full;

   assign full    = {{KEY_W{1'b0}}, op_a} * {{KEY_W{1'b0}}, op_b};
   assign product = full[KEY_W-1:0];

endmodule : msc_mul

`default_nettype wire

// ===== sv/msc_keys.sv =====
// Key register file: six 64-bit key pairs written through the CSR port.
// Reads one 32-bit key by index with its low bit forced to one. Uses msc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msc_keys (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire msc_pkg::csr_addr_type csr_addr,
   input  wire msc_pkg::word_type     csr_wdata,
   input  wire msc_pkg::kidx_type     key_idx,
   output msc_pkg::half_type          key_value
);
   import msc_pkg::*;

   word_type pair_ff [NUM_PAIRS];
   word_type pair_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAIRS; i++) begin
            pair_ff[i] <= '0;
         end
      end else if (csr_we && (32'(csr_addr) < NUM_PAIRS)) begin
         pair_ff[csr_addr] <= csr_wdata;
      end
   end

   always_comb begin
      if (32'(key_idx[KIDX_W-1:1]) < NUM_PAIRS) begin
         pair_sel = pair_ff[key_idx[KIDX_W-1:1]];
      end else begin
         pair_sel = '0;
      end
   end

   assign key_value = (key_idx[0] ? pair_sel[WORD_W-1:KEY_W] : pair_sel[KEY_W-1:0]) |
                      half_type'(1);

endmodule : msc_keys

`default_nettype wire

// ===== sv/multiswap_chain_decrypt_core.sv =====
// MultiSwap chain-and-decrypt core: sequencer and datapath around one shared multiplier.
// Depends on msc_pkg, msc_keys and msc_mul.
//
// Usage:
// Each item on the req_ channel is one 64-bit packet word; req_tlast marks the
// final word of the packet. A word without req_tlast is folded into the chain
// value and produces no result. The word with req_tlast is decrypted under the
// chain value, one 64-bit result item goes out on the rsp_ channel, and the
// chain value returns to zero.
// The core handles one item at a time and takes req_ items only while idle.
// Between accepting a chained word and the next acceptance lie ten
// multiplications through the single shared multiplier plus the key and chain
// additions. For a last word the same multiplier also forms the ten key inverses
// by Newton iteration.
// The result sits in an output register; while the receiver stalls the core
// keeps taking and chaining words, and only a following last word waits for
// the output register to empty.
// Reset clears the six key pairs, the chain value and any pending result. Keys must
// be written through csr_ while no item is in progress; the core does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module multiswap_chain_decrypt_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire msc_pkg::word_type     req_tdata,   // data_word[63:0]
   input  wire                        req_tlast,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output msc_pkg::word_type          rsp_tdata,   // plain_word[63:0]
   input  wire                        csr_we,
   input  wire msc_pkg::csr_addr_type csr_addr,
   input  wire msc_pkg::word_type     csr_wdata
);
   import msc_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_F_ADD   = 5'd1;
   localparam logic [4:0] ST_F_MUL   = 5'd2;
   localparam logic [4:0] ST_F_KADD  = 5'd3;
   localparam logic [4:0] ST_F_MID   = 5'd4;
   localparam logic [4:0] ST_F_END   = 5'd5;
   localparam logic [4:0] ST_I_START = 5'd6;
   localparam logic [4:0] ST_I_KSUB  = 5'd7;
   localparam logic [4:0] ST_I_SQ    = 5'd8;
   localparam logic [4:0] ST_I_CUBE  = 5'd9;
   localparam logic [4:0] ST_I_NY    = 5'd10;
   localparam logic [4:0] ST_I_NSUB  = 5'd11;
   localparam logic [4:0] ST_I_NX    = 5'd12;
   localparam logic [4:0] ST_I_APPLY = 5'd13;
   localparam logic [4:0] ST_I_MID   = 5'd14;
   localparam logic [4:0] ST_I_MID2  = 5'd15;
   localparam logic [4:0] ST_I_END   = 5'd16;

   localparam kidx_type KIDX_BASE0 = kidx_type'(0);
   localparam kidx_type KIDX_LAST0 = kidx_type'(4);
   localparam kidx_type KIDX_ADD0  = kidx_type'(5);
   localparam kidx_type KIDX_BASE1 = kidx_type'(6);
   localparam kidx_type KIDX_LAST1 = kidx_type'(10);
   localparam kidx_type KIDX_ADD1  = kidx_type'(11);
   localparam half_type NEWTON_TWO = half_type'(2);
   localparam logic [1:0] NEWTON_LAST = 2'd2;

   function automatic half_type swap16(input half_type v);
      swap16 = {v[KEY_W/2-1:0], v[KEY_W-1:KEY_W/2]};
   endfunction

   logic [4:0] state_ff, state_in;
   kidx_type   kidx_ff, kidx_in;
   logic [1:0] newton_ff, newton_in;
   word_type   data_ff, data_in;
   word_type   chain_ff, chain_in;
   half_type   acc_ff, acc_in;
   half_type   inv_ff, inv_in;
   half_type   tmp_ff, tmp_in;
   half_type   c_ff, c_in;
   half_type   b_ff, b_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_data_ff, rsp_data_in;

   half_type key_value;
   half_type mul_a, mul_b, product;
   half_type chain_lo, chain_hi, data_lo, data_hi;
   logic     at_base;

   msc_keys u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .key_idx   (kidx_ff),
      .key_value (key_value)
   );

   msc_mul u_mul (
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign chain_lo = chain_ff[KEY_W-1:0];
   assign chain_hi = chain_ff[WORD_W-1:KEY_W];
   assign data_lo  = data_ff[KEY_W-1:0];
   assign data_hi  = data_ff[WORD_W-1:KEY_W];
   assign at_base  = (kidx_ff == KIDX_BASE0) || (kidx_ff == KIDX_BASE1);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      unique case (state_ff)
         ST_F_MUL: begin
            mul_a = at_base ? acc_ff : swap16(acc_ff);
            mul_b = key_value;
         end
         ST_I_SQ: begin
            mul_a = key_value;
            mul_b = key_value;
         end
         ST_I_CUBE: begin
            mul_a = inv_ff;
            mul_b = key_value;
         end
         ST_I_NY: begin
            mul_a = key_value;
            mul_b = inv_ff;
         end
         ST_I_NX: begin
            mul_a = inv_ff;
            mul_b = tmp_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = inv_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kidx_in      = kidx_ff;
      newton_in    = newton_ff;
      data_in      = data_ff;
      chain_in     = chain_ff;
      acc_in       = acc_ff;
      inv_in       = inv_ff;
      tmp_in       = tmp_ff;
      c_in         = c_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               data_in  = req_tdata;
               state_in = req_tlast ? ST_I_START : ST_F_ADD;
            end
         end
         ST_F_ADD: begin
            acc_in   = data_lo + chain_lo;
            kidx_in  = KIDX_BASE0;
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            acc_in  = product;
            kidx_in = kidx_ff + kidx_type'(1);
            if ((kidx_ff == KIDX_LAST0) || (kidx_ff == KIDX_LAST1)) begin
               state_in = ST_F_KADD;
            end
         end
         ST_F_KADD: begin
            acc_in   = acc_ff + key_value;
            kidx_in  = kidx_ff + kidx_type'(1);
            state_in = (kidx_ff == KIDX_ADD0) ? ST_F_MID : ST_F_END;
         end
         ST_F_MID: begin
            acc_in   = data_hi + acc_ff;
            c_in     = chain_hi + acc_ff;
            state_in = ST_F_MUL;
         end
         ST_F_END: begin
            chain_in = {c_ff + acc_ff, acc_ff};
            state_in = ST_IDLE;
         end
         ST_I_START: begin
            c_in     = data_hi - data_lo;
            acc_in   = data_lo;
            kidx_in  = KIDX_ADD1;
            state_in = ST_I_KSUB;
         end
         ST_I_KSUB: begin
            acc_in   = acc_ff - key_value;
            kidx_in  = kidx_ff - kidx_type'(1);
            state_in = ST_I_SQ;
         end
         ST_I_SQ: begin
            inv_in   = product;
            state_in = ST_I_CUBE;
         end
         ST_I_CUBE: begin
            inv_in    = product;
            newton_in = '0;
            state_in  = ST_I_NY;
         end
         ST_I_NY: begin
            tmp_in   = product;
            state_in = ST_I_NSUB;
         end
         ST_I_NSUB: begin
            tmp_in   = NEWTON_TWO - tmp_ff;
            state_in = ST_I_NX;
         end
         ST_I_NX: begin
            inv_in    = product;
            newton_in = newton_ff + 2'd1;
            state_in  = (newton_ff == NEWTON_LAST) ? ST_I_APPLY : ST_I_NY;
         end
         ST_I_APPLY: begin
            acc_in = at_base ? product : swap16(product);
            if (kidx_ff == KIDX_BASE1) begin
               state_in = ST_I_MID;
            end else if (kidx_ff == KIDX_BASE0) begin
               state_in = ST_I_END;
            end else begin
               kidx_in  = kidx_ff - kidx_type'(1);
               state_in = ST_I_SQ;
            end
         end
         ST_I_MID: begin
            c_in     = c_ff - chain_hi;
            b_in     = acc_ff;
            state_in = ST_I_MID2;
         end
         ST_I_MID2: begin
            b_in     = b_ff - c_ff;
            acc_in   = c_ff;
            kidx_in  = KIDX_ADD0;
            state_in = ST_I_KSUB;
         end
         ST_I_END: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {b_ff, acc_ff - chain_lo};
               chain_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kidx_ff      <= '0;
         newton_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         kidx_ff      <= kidx_in;
         newton_ff    <= newton_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      acc_ff      <= acc_in;
      inv_ff      <= inv_in;
      tmp_ff      <= tmp_in;
      c_ff        <= c_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : multiswap_chain_decrypt_core

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for multiswap_chain_decrypt_core: chained and last words,
// key programming and random idling on both stream sides.
// Depends on msc_pkg and the core RTL; a class predicts the decrypted words.
`timescale 1ns / 1ps

module tb_top;
   import msc_pkg::*;

   typedef enum logic [CSR_ADDR_W-1:0] {
      KEY_PAIR_0, KEY_PAIR_1, KEY_PAIR_2, KEY_PAIR_3, KEY_PAIR_4, KEY_PAIR_5,
      SPARE_6, SPARE_7
   } reg_index_e;

   localparam int NUM_REGS     = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int TAIL_CYCLES   = 150;

   class msc_decrypt_tracker;
      word_type key_pair[NUM_PAIRS];
      word_type chain;
      word_type plain_due[$];
      int       errors;

      function new();
         foreach (key_pair[i]) key_pair[i] = '0;
         chain  = '0;
         errors = 0;
      endfunction

      function void write_reg(csr_addr_type addr, word_type value);
         if (addr <= KEY_PAIR_5) key_pair[addr] = value;
      endfunction

      function half_type key_at(int idx);
         word_type pair;
         pair = key_pair[idx / 2];
         return ((idx % 2) ? pair[63:32] : pair[31:0]) | half_type'(1);
      endfunction

      function half_type swap_halves(half_type v);
         return {v[15:0], v[31:16]};
      endfunction

      function half_type inv_odd(half_type v);
         half_type x;
         x = v * v * v;
         repeat (3) x = x * (half_type'(2) - v * x);
         return x;
      endfunction

      function half_type fwd_mix(int base, half_type v);
         v = v * key_at(base);
         for (int i = 1; i < 5; i++) v = swap_halves(v) * key_at(base + i);
         return v + key_at(base + 5);
      endfunction

      function half_type inv_mix(int base, half_type v);
         v = v - key_at(base + 5);
         for (int i = 4; i > 0; i--) v = swap_halves(v * inv_odd(key_at(base + i)));
         return v * inv_odd(key_at(base));
      endfunction

      function void take_word(word_type w, logic last);
         half_type lo, hi, a, b, c, t;
         lo = chain[31:0];
         hi = chain[63:32];
         if (!last) begin
            t = fwd_mix(0, w[31:0] + lo);
            b = w[63:32] + t;
            c = hi + t;
            t = fwd_mix(6, b);
            chain = {c + t, t};
         end else begin
            t = w[31:0];
            c = w[63:32] - t;
            b = inv_mix(6, t);
            t = c - hi;
            b = b - t;
            a = inv_mix(0, t) - lo;
            plain_due.push_back({b, a});
            chain = '0;
         end
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_plain(word_type got);
         word_type want;
         if (plain_due.size() == 0) begin
            report_mismatch($sformatf("unexpected plain_word %h", got));
         end else begin
            want = plain_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("plain_word %h, predicted %h", got, want));
         end
      endtask

      function int pending();
         return plain_due.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   word_type     req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   word_type     rsp_tdata;
   logic         csr_we;
   csr_addr_type csr_addr;
   word_type     csr_wdata;

   msc_decrypt_tracker tracker = new();
   int send_idle_pct;
   int recv_stall_pct;

   multiswap_chain_decrypt_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_plain(rsp_tdata);
   end

   function automatic half_type pick_key_half();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return half_type'(1);
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type pick_data();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, 63);
         3: return ~(word_type'(1) << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(word_type data, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tlast  <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_word(data, last);
      @(negedge clock);
   endtask

   task automatic wait_idle(int extra);
      req_tvalid <= 1'b0;
      while (tracker.pending() > 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // Writes all six key pairs plus the two unused indexes, which must be ignored.
   task automatic program_keys(word_type keys[NUM_PAIRS]);
      word_type value;
      for (int i = 0; i < NUM_REGS; i++) begin
         value = (i < NUM_PAIRS) ? keys[i] : {$urandom, $urandom};
         csr_we    <= 1'b1;
         csr_addr  <= reg_index_e'(i);
         csr_wdata <= value;
         tracker.write_reg(reg_index_e'(i), value);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_random_keys();
      word_type keys[NUM_PAIRS];
      foreach (keys[i]) keys[i] = {pick_key_half(), pick_key_half()};
      program_keys(keys);
   endtask

   task automatic send_packets(int n_words);
      int sent;
      int chained;
      sent = 0;
      while (sent < n_words) begin
         chained = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
         repeat (chained) send_word(pick_data(), 1'b0);
         send_word(pick_data(), 1'b1);
         sent += chained + 1;
      end
   endtask

   initial begin
      word_type keys[NUM_PAIRS];
      int idle_table[4];
      int stall_table[4];
      idle_table  = '{0, 69, 0, 26};
      stall_table = '{0, 0, 69, 26};
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = KEY_PAIR_0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset keys all act as one; a last word with no chain decrypts under zero.
      send_word('0, 1'b1);
      send_word('1, 1'b1);
      send_word('0, 1'b0);
      send_word('1, 1'b0);
      send_word(64'h8000_0000_0000_0001, 1'b1);
      wait_idle(SETTLE_CYCLES);

      foreach (keys[i]) keys[i] = '1;
      program_keys(keys);
      send_word('1, 1'b0);
      send_word('0, 1'b1);
      send_word(64'h0123_4567_89AB_CDEF, 1'b0);
      send_word(64'hFEDC_BA98_7654_3210, 1'b0);
      send_word(64'h5555_5555_AAAA_AAAA, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // Even key values check that bit zero is forced high.
      foreach (keys[i]) keys[i] = 64'hAAAA_AAAA_5555_5554 ^ (word_type'(i) << 8);
      program_keys(keys);
      send_word(64'hDEAD_BEEF_0BAD_F00D, 1'b0);
      send_word(64'h0000_0001_8000_0000, 1'b0);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(64'hFFFF_FFFF_0000_0000, 1'b0);
      wait_idle(SETTLE_CYCLES);

      // A key change in the middle of a packet takes effect at once.
      foreach (keys[i]) keys[i] = '0;
      program_keys(keys);
      send_word(64'h0000_0000_FFFF_FFFF, 1'b0);
      wait_idle(SETTLE_CYCLES);
      program_random_keys();
      send_word(64'h1357_9BDF_2468_ACE0, 1'b1);
      wait_idle(SETTLE_CYCLES);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_table[phase];
         recv_stall_pct = stall_table[phase];
         program_random_keys();
         send_packets(66);
         wait_idle(SETTLE_CYCLES);
         program_random_keys();
         send_packets(66);
         wait_idle(SETTLE_CYCLES);
      end

      wait_idle(TAIL_CYCLES);
      if (tracker.errors == 0) begin
         $display("multiswap_chain_decrypt_core regression: pass");
      end else begin
         $display("multiswap_chain_decrypt_core regression: fail");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("multiswap_chain_decrypt_core regression: fail");
      $finish;
   end

endmodule
